// ===== sv/msq_pkg.sv =====
// Package for the musical scale quantiser: codes, the configuration struct
// and the small arithmetic helpers used by the datapath and the register file.
// No dependencies.
package msq_pkg;

	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ROOT_NOTE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 1'b1;

	localparam logic [1:0] CMD_NEAREST = 2'd0;
	localparam logic [1:0] CMD_UP      = 2'd1;
	localparam logic [1:0] CMD_DOWN    = 2'd2;

	localparam logic [2:0] SCALE_CHROMATIC = 3'd0;
	localparam logic [2:0] SCALE_MAJOR     = 3'd1;
	localparam logic [2:0] SCALE_MINOR     = 3'd2;
	localparam logic [2:0] SCALE_PENTA_MAJ = 3'd3;
	localparam logic [2:0] SCALE_PENTA_MIN = 3'd4;

	// Bit k of a mask is set when pitch class k above the root is in the scale.
	localparam logic [11:0] MASK_CHROMATIC = 12'hFFF;
	localparam logic [11:0] MASK_MAJOR     = 12'b1010_1011_0101;
	localparam logic [11:0] MASK_MINOR     = 12'b0101_1010_1101;
	localparam logic [11:0] MASK_PENTA_MAJ = 12'b0010_1001_0101;
	localparam logic [11:0] MASK_PENTA_MIN = 12'b0100_1010_1001;

	typedef struct packed {
		logic [3:0]  root_pc;
		logic [11:0] mask;
	} msq_cfg_t;

	function automatic logic [11:0] scale_mask(input logic [2:0] sel);
		logic [11:0] m;
		unique case (sel)
			SCALE_MAJOR:     m = MASK_MAJOR;
			SCALE_MINOR:     m = MASK_MINOR;
			SCALE_PENTA_MAJ: m = MASK_PENTA_MAJ;
			SCALE_PENTA_MIN: m = MASK_PENTA_MIN;
			default:         m = MASK_CHROMATIC;
		endcase
		return m;
	endfunction

	// v mod 12, split as v = 4a + b so that only a mod 3 needs a reciprocal.
	function automatic logic [3:0] mod12(input logic [8:0] v);
		logic [6:0]  a;
		logic [14:0] p;
		logic [5:0]  q;
		logic [7:0]  t;
		a = v[8:2];
		p = 15'(a) * 15'd171;
		q = p[14:9];
		t = 8'(a) - 8'(q) * 8'd3;
		return {t[1:0], v[1:0]};
	endfunction

	// Semitones from pitch class pc up to the nearest scale member (0 to 3).
	function automatic logic [1:0] dist_up(input logic [11:0] m, input logic [3:0] pc);
		logic [1:0] d;
		logic       found;
		logic [4:0] idx;
		d = 2'd0;
		found = 1'b0;
		for (int k = 0; k < 4; k++) begin
			idx = 5'(pc) + 5'(k);
			if (idx >= 5'd12) begin
				idx = idx - 5'd12;
			end
			if (!found && m[idx[3:0]]) begin
				d = 2'(k);
				found = 1'b1;
			end
		end
		return d;
	endfunction

	// Semitones from pitch class pc down to the nearest scale member (0 to 3).
	function automatic logic [1:0] dist_dn(input logic [11:0] m, input logic [3:0] pc);
		logic [1:0] d;
		logic       found;
		logic [4:0] idx;
		d = 2'd0;
		found = 1'b0;
		for (int k = 0; k < 4; k++) begin
			idx = 5'(pc) + 5'd12 - 5'(k);
			if (idx >= 5'd12) begin
				idx = idx - 5'd12;
			end
			if (!found && m[idx[3:0]]) begin
				d = 2'(k);
				found = 1'b1;
			end
		end
		return d;
	endfunction

endpackage

// ===== sv/msq_if.sv =====
// Handshake channels of the musical scale quantiser: the pitch request
// channel and the result channel. Depends on nothing.
interface msq_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        command;
	logic signed [15:0] pitch_offset;

	modport source (output valid, command, pitch_offset, input ready);
	modport sink (input valid, command, pitch_offset, output ready);
endinterface

interface msq_out_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] snapped_pitch;

	modport source (output valid, snapped_pitch, input ready);
	modport sink (input valid, snapped_pitch, output ready);
endinterface

// ===== sv/msq_cfg.sv =====
// Configuration registers of the musical scale quantiser. The root is kept
// already reduced modulo 12 and the scale as its pitch-class mask. Uses msq_pkg.
module msq_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [msq_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [msq_pkg::CFG_DATA_W-1:0] wr_data,
	output msq_pkg::msq_cfg_t             cfg
);
	import msq_pkg::*;

	logic [3:0]  root_pc_q;
	logic [11:0] mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_pc_q <= 4'd0;
			mask_q    <= MASK_CHROMATIC;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROOT_NOTE:    root_pc_q <= mod12({1'b0, wr_data});
				REG_SCALE_SELECT: mask_q <= scale_mask(wr_data[2:0]);
				default:          ;
			endcase
		end
	end

	assign cfg.root_pc = root_pc_q;
	assign cfg.mask    = mask_q;

endmodule

// ===== sv/msq_snap.sv =====
// Snapping datapath of the musical scale quantiser: finds the scale pitches
// at or below and at or above the input and picks one by command. Uses msq_pkg.
module msq_snap (
	input  msq_pkg::msq_cfg_t  cfg,
	input  logic [1:0]         command,
	input  logic signed [15:0] pitch_offset,
	output logic signed [8:0]  snapped_pitch
);
	import msq_pkg::*;

	logic [7:0]  whole;
	logic [7:0]  frac;
	logic        frac_nz;
	logic [8:0]  whole_ext;
	logic [8:0]  rel;
	logic [3:0]  pc;
	logic [3:0]  pc_up;
	logic [1:0]  d_up;
	logic [1:0]  d_dn;
	logic [2:0]  step_up;
	logic [8:0]  up_pitch;
	logic [8:0]  dn_pitch;
	logic [9:0]  gap_dn;
	logic [10:0] gap_up;

	assign whole     = pitch_offset[15:8];
	assign frac      = pitch_offset[7:0];
	assign frac_nz   = |frac;
	assign whole_ext = {whole[7], whole};

	// Adding twelve octaves keeps the value positive before the reduction.
	assign rel = whole_ext + 9'd144 - {5'd0, cfg.root_pc};
	assign pc  = mod12(rel);

	// With a fraction the upward search starts one semitone above the floor.
	always_comb begin
		if (!frac_nz) begin
			pc_up = pc;
		end else if (pc == 4'd11) begin
			pc_up = 4'd0;
		end else begin
			pc_up = pc + 4'd1;
		end
	end

	assign d_up     = dist_up(cfg.mask, pc_up);
	assign d_dn     = dist_dn(cfg.mask, pc);
	assign step_up  = {2'b0, frac_nz} + {1'b0, d_up};
	assign up_pitch = whole_ext + {6'd0, step_up};
	assign dn_pitch = whole_ext - {7'd0, d_dn};

	// Distances to the two candidates in unsigned Q2.8 and Q3.8; a tie goes to the lower one.
	assign gap_dn = {d_dn, frac};
	assign gap_up = {step_up, 8'd0} - {3'd0, frac};

	always_comb begin
		unique case (command)
			CMD_UP:   snapped_pitch = up_pitch;
			CMD_DOWN: snapped_pitch = dn_pitch;
			default: begin
				if ({1'b0, gap_dn} <= gap_up) begin
					snapped_pitch = dn_pitch;
				end else begin
					snapped_pitch = up_pitch;
				end
			end
		endcase
	end

endmodule

// ===== sv/musical_scale_quantizer.sv =====
// Musical scale quantiser, top level.
// A request on in_ch carries a command (nearest, up or down) and a pitch in
// signed Q8.8 semitones; the result on out_ch is the chosen pitch of the
// selected scale in whole signed semitones, one result per request, in order.
// The root note and scale are written through the wr_en/wr_index/wr_data port
// while no request is in flight; they take effect on the next request.
// The input register takes a request when it is accepted; the snapping logic
// fills the result register from it once that register has room, and the
// result is offered from there. Throughput is one request per cycle while
// the receiver takes results; the input register and the result register
// each hold one request, so a new request is taken while a finished result
// waits. When the receiver stalls, the result holds and the input side keeps
// accepting until both registers are full.
// Reset clears both valid flags, sets the root to zero and the scale to
// chromatic. Uses msq_pkg, msq_if, msq_cfg and msq_snap.
module musical_scale_quantizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [msq_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [msq_pkg::CFG_DATA_W-1:0] wr_data,
	msq_in_if.sink                        in_ch,
	msq_out_if.source                     out_ch
);
	import msq_pkg::*;

	msq_cfg_t cfg;

	logic              v_s1;
	logic [1:0]        cmd_s1;
	logic signed [15:0] pitch_s1;
	logic              v_s2;
	logic signed [8:0] res_s2;
	logic signed [8:0] snap;
	logic              rdy1;
	logic              rdy2;

	msq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	msq_snap u_snap (
		.cfg           (cfg),
		.command       (cmd_s1),
		.pitch_offset  (pitch_s1),
		.snapped_pitch (snap)
	);

	assign rdy2        = !v_s2 || out_ch.ready;
	assign rdy1        = !v_s1 || rdy2;
	assign in_ch.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_ch.valid) begin
			cmd_s1   <= in_ch.command;
			pitch_s1 <= in_ch.pitch_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			res_s2 <= snap;
		end
	end

	assign out_ch.valid         = v_s2;
	assign out_ch.snapped_pitch = res_s2;

`ifndef SYNTHESIS
	// An accepted request always occupies the input register next cycle.
	a_in_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> v_s1)
		else $error("accepted request did not reach the input register");

	// A request in the input register moves on whenever the result side has room.
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rdy2) |=> v_s2)
		else $error("request lost between input and result registers");

	// A full pipeline refuses new requests.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && !out_ch.ready) |-> !in_ch.ready)
		else $error("request accepted while both registers are full");

	// Snapped pitches stay within three semitones of the input range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (res_s2 >= -9'sd131 && res_s2 <= 9'sd131))
		else $error("snapped pitch out of range");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for musical_scale_quantizer: directed table, then random
// phases under many root/scale tunings, each result checked against the table or the bench's own predictor.
// Depends on msq_pkg, msq_in_if, msq_out_if and the quantiser RTL.
module testbench;
	import msq_pkg::*;

	localparam logic [1:0] CMD_SPARE       = 2'd3;
	localparam logic [2:0] SCALE_UNUSED_LO = 3'd5;
	localparam logic [2:0] SCALE_CODE_MAX  = 3'd7;

	localparam int Q_ONE    = 256;
	localparam int OCTAVE_Q = 12 * Q_ONE;
	localparam int SETTLE   = 6;
	localparam int PHASES   = 14;
	localparam int PER_PHASE = 125;

	// Pitch classes above the root, bit k for class k.
	localparam logic [11:0] MAJOR_SET     = 12'b1010_1011_0101; // 0 2 4 5 7 9 11
	localparam logic [11:0] MINOR_SET     = 12'b0101_1010_1101; // 0 2 3 5 7 8 10
	localparam logic [11:0] PENTA_MAJ_SET = 12'b0010_1001_0101; // 0 2 4 7 9
	localparam logic [11:0] PENTA_MIN_SET = 12'b0100_1010_1001; // 0 3 5 7 10

	typedef struct packed {
		logic [7:0]        root;
		logic [2:0]        scale;
		logic [1:0]        cmd;
		logic [15:0]       pitch;
		logic              known;
		logic signed [8:0] snapped;
	} tone_case_t;

	localparam int N_DIRECTED = 24;
	localparam tone_case_t DIRECTED_CASES [N_DIRECTED] = '{
		'{8'd0,   SCALE_CHROMATIC, CMD_NEAREST, 16'h0000, 1'b1, 9'sd0},
		'{8'd0,   SCALE_CHROMATIC, CMD_NEAREST, 16'h0080, 1'b1, 9'sd0},
		'{8'd0,   SCALE_CHROMATIC, CMD_NEAREST, 16'h7FFF, 1'b1, 9'sd128},
		'{8'd0,   SCALE_CHROMATIC, CMD_NEAREST, 16'h8000, 1'b1, -9'sd128},
		'{8'd0,   SCALE_CHROMATIC, CMD_UP,      16'h7FFF, 1'b1, 9'sd128},
		'{8'd0,   SCALE_CHROMATIC, CMD_DOWN,    16'h7FFF, 1'b1, 9'sd127},
		'{8'd0,   SCALE_CHROMATIC, CMD_DOWN,    16'h8001, 1'b1, -9'sd128},
		'{8'd0,   SCALE_CHROMATIC, CMD_UP,      16'h8001, 1'b1, -9'sd127},
		'{8'd0,   SCALE_CHROMATIC, CMD_SPARE,   16'h0180, 1'b1, 9'sd1},
		'{8'd0,   SCALE_CHROMATIC, CMD_NEAREST, 16'hFFFF, 1'b1, 9'sd0},
		'{8'd0,   SCALE_CHROMATIC, CMD_DOWN,    16'hFFFF, 1'b1, -9'sd1},
		'{8'd0,   SCALE_CODE_MAX,  CMD_NEAREST, 16'h0140, 1'b1, 9'sd1},
		'{8'd0,   SCALE_UNUSED_LO, CMD_UP,      16'h0140, 1'b1, 9'sd2},
		'{8'd0,   SCALE_MAJOR,     CMD_NEAREST, 16'h0100, 1'b1, 9'sd0},
		'{8'd0,   SCALE_MAJOR,     CMD_UP,      16'h0100, 1'b1, 9'sd2},
		'{8'd0,   SCALE_MAJOR,     CMD_DOWN,    16'h0100, 1'b1, 9'sd0},
		'{8'd0,   SCALE_MAJOR,     CMD_NEAREST, 16'h0600, 1'b1, 9'sd5},
		'{8'd0,   SCALE_MAJOR,     CMD_SPARE,   16'h0B80, 1'b1, 9'sd11},
		'{8'd255, SCALE_MAJOR,     CMD_NEAREST, 16'h0300, 1'b1, 9'sd3},
		'{8'd255, SCALE_PENTA_MIN, CMD_UP,      16'h7FFF, 1'b0, 9'sd0},
		'{8'd12,  SCALE_PENTA_MIN, CMD_DOWN,    16'h8000, 1'b0, 9'sd0},
		'{8'd11,  SCALE_PENTA_MAJ, CMD_UP,      16'h7FFF, 1'b0, 9'sd0},
		'{8'd5,   SCALE_MINOR,     CMD_NEAREST, 16'h8000, 1'b0, 9'sd0},
		'{8'd128, SCALE_PENTA_MAJ, CMD_DOWN,    16'h8000, 1'b0, 9'sd0}
	};

	localparam logic [7:0] PHASE_ROOTS [7] = '{8'd0, 8'd255, 8'd11, 8'd12, 8'd128, 8'd7, 8'd200};
	localparam logic [2:0] PHASE_SCALES [7] = '{SCALE_CHROMATIC, SCALE_PENTA_MIN, SCALE_MAJOR,
		SCALE_MINOR, SCALE_PENTA_MAJ, SCALE_UNUSED_LO, SCALE_CODE_MAX};

	typedef enum logic [1:0] {
		SINK_FREE,
		SINK_MOSTLY,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_e;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	msq_in_if  in_ch ();
	msq_out_if out_ch ();

	musical_scale_quantizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	logic signed [8:0] snaps_due [$];
	logic [7:0]        cur_root  = 8'd0;
	logic [2:0]        cur_scale = SCALE_CHROMATIC;
	int                snaps_checked = 0;
	int                mismatches = 0;
	int                tunings = 0;
	int                cmd_seen [4] = '{0, 0, 0, 0};
	sink_mode_e        sink_mode = SINK_FREE;
	int                sink_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int floor_div(input int a, input int b);
		if (a >= 0) begin
			return a / b;
		end
		return -((-a + b - 1) / b);
	endfunction

	// Searches five octaves around the input, measured from the root, exactly in Q8.8.
	function automatic logic signed [8:0] snap_to_scale(input logic [1:0] cmd,
			input logic signed [15:0] pitch, input logic [7:0] root, input logic [2:0] scale);
		int          x, r, base, cand, delta, gap, best, best_gap;
		logic        found, want_up, want_down;
		logic [11:0] members;
		x = int'(pitch);
		r = int'(root) % 12;
		want_up = (cmd == CMD_UP);
		want_down = (cmd == CMD_DOWN);
		case (scale)
			SCALE_MAJOR:     members = MAJOR_SET;
			SCALE_MINOR:     members = MINOR_SET;
			SCALE_PENTA_MAJ: members = PENTA_MAJ_SET;
			SCALE_PENTA_MIN: members = PENTA_MIN_SET;
			default:         members = 12'hFFF;
		endcase
		base = floor_div(x - r * Q_ONE, OCTAVE_Q);
		best = floor_div(x, Q_ONE);
		best_gap = 0;
		found = 1'b0;
		for (int oct = base - 2; oct <= base + 2; oct++) begin
			for (int pc = 0; pc < 12; pc++) begin
				if (members[pc]) begin
					cand = oct * 12 + r + pc;
					delta = cand * Q_ONE - x;
					gap = (delta < 0) ? -delta : delta;
					if (!(want_up && delta < 0) && !(want_down && delta > 0)) begin
						if (!found || gap < best_gap || (gap == best_gap && cand < best)) begin
							best = cand;
							best_gap = gap;
							found = 1'b1;
						end
					end
				end
			end
		end
		return best[8:0];
	endfunction

	// Biased towards whole and half semitones so that ties and exact hits are common.
	function automatic logic [15:0] random_pitch();
		logic [15:0] p;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: p = 16'($urandom);
			4, 5:       p = {8'($urandom), 8'h00};
			6:          p = {8'($urandom), 8'h80};
			7:          p = {8'($urandom), ($urandom_range(0, 1) != 0) ? 8'h01 : 8'hFF};
			8: begin
				case ($urandom_range(0, 4))
					0:       p = 16'h8000;
					1:       p = 16'h8001;
					2:       p = 16'h7FFF;
					3:       p = 16'hFFFF;
					default: p = 16'h0000;
				endcase
			end
			default:    p = 16'($urandom_range(0, 2 * OCTAVE_Q) - OCTAVE_Q);
		endcase
		return p;
	endfunction

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input logic [1:0] cmd, input logic [15:0] pitch,
			input logic signed [8:0] snapped);
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.pitch_offset <= pitch;
		do @(posedge clk); while (!in_ch.ready);
		snaps_due.push_back(snapped);
		cmd_seen[cmd]++;
		@(negedge clk);
	endtask

	task automatic hold_off(input int cycles);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic await_idle();
		hold_off(1);
		while (snaps_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_tuning(input logic [7:0] root, input logic [2:0] scale);
		await_idle();
		write_reg(REG_ROOT_NOTE, root);
		write_reg(REG_SCALE_SELECT, CFG_DATA_W'(scale));
		cur_root = root;
		cur_scale = scale;
		tunings++;
	endtask

	// The receiver picks a new random stall behaviour whenever its countdown sink_left runs out.
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode <= sink_mode_e'($urandom_range(0, 3));
			sink_left <= $urandom_range(20, 200);
		end else begin
			sink_left <= sink_left - 1;
		end
		case (sink_mode)
			SINK_FREE:   out_ch.ready <= 1'b1;
			SINK_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
			SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
			default:     out_ch.ready <= (sink_left % 5 != 0);
		endcase
	end

	always @(posedge clk) begin
		logic signed [8:0] want;
		if (out_ch.valid && out_ch.ready) begin
			if (snaps_due.size() == 0) begin
				$display("%0t: unexpected result, snapped_pitch %0d with nothing outstanding",
					$time, out_ch.snapped_pitch);
				mismatches++;
			end else begin
				want = snaps_due.pop_front();
				snaps_checked++;
				if (out_ch.snapped_pitch !== want) begin
					$display("%0t: snapped_pitch expected %0d, actual %0d",
						$time, want, out_ch.snapped_pitch);
					mismatches++;
				end
			end
		end
	end

	initial begin
		tone_case_t        row;
		logic [1:0]        cmd;
		logic [15:0]       pitch;
		logic signed [8:0] snapped;
		int                burst_left;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_NEAREST;
		in_ch.pitch_offset = 16'sd0;
		out_ch.ready = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_ROOT_NOTE;
		wr_data = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = DIRECTED_CASES[i];
			if (row.root != cur_root || row.scale != cur_scale) begin
				set_tuning(row.root, row.scale);
			end
			snapped = row.known ? row.snapped
				: snap_to_scale(row.cmd, row.pitch, cur_root, cur_scale);
			send_request(row.cmd, row.pitch, snapped);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < 7) begin
				set_tuning(PHASE_ROOTS[phase], PHASE_SCALES[phase]);
			end else begin
				set_tuning(8'($urandom), 3'($urandom_range(0, SCALE_CODE_MAX)));
			end
			burst_left = $urandom_range(1, 40);
			for (int n = 0; n < PER_PHASE; n++) begin
				// Once, let the pipeline empty completely in the middle of a phase.
				if (phase == 3 && n == PER_PHASE / 2) begin
					await_idle();
				end
				cmd = 2'($urandom_range(0, 3));
				pitch = random_pitch();
				send_request(cmd, pitch, snap_to_scale(cmd, pitch, cur_root, cur_scale));
				burst_left--;
				if (burst_left == 0) begin
					hold_off($urandom_range(1, 8));
					burst_left = ($urandom_range(0, 3) == 0) ? 120 : $urandom_range(1, 20);
				end
			end
		end

		await_idle();
		$display("Checked %0d results across %0d tunings of root and scale.",
			snaps_checked, tunings);
		$display("Requests by command: nearest %0d, up %0d, down %0d, unused code %0d.",
			cmd_seen[CMD_NEAREST], cmd_seen[CMD_UP], cmd_seen[CMD_DOWN], cmd_seen[CMD_SPARE]);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/msq_pkg.sv
sv/msq_if.sv
sv/msq_cfg.sv
sv/msq_snap.sv
sv/musical_scale_quantizer.sv
bench/testbench.sv
